FILE: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types and constants of the stream substring deleter
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int BYTE_W          = 8;
    localparam int DEF_MAX_PATTERN = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_LEN_W       = 5;
    localparam int BYTES_PER_WORD  = CFG_DATA_W / BYTE_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    // one input item
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_present;
        logic              run_last;
        logic              text_done;
    } t_out_item;

    // view of the shared pattern select and compare unit
    typedef struct packed {
        logic [BYTE_W-1:0] sel_byte;
        logic              byte_eq;
    } t_pat_view;

endpackage

FILE: rtl/ssd_stream_if.sv
// ----------------------------------------------------------------------------
// ssd_stream_if
// valid/ready stream channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface ssd_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ssd_pattern.sv
// ----------------------------------------------------------------------------
// ssd_pattern
// pattern registers with the shared byte select and compare unit
// ----------------------------------------------------------------------------
module ssd_pattern
    import ssd_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0]      i_sel_idx,
    input  logic [BYTE_W-1:0]     i_cmp_byte,
    output t_pat_view             o_view,
    output logic [LEN_W-1:0]      o_eff_len
);

    logic [BYTE_W-1:0]    r_pat [MAX_PATTERN];
    logic [CFG_LEN_W-1:0] r_len;
    logic [CFG_LEN_W-1:0] len_clamped;
    logic [BYTE_W-1:0]    sel_byte;

    // pattern byte registers, each fed from its fixed lane of a config word
    for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_pat
        if (gi < BYTES_PER_WORD) begin : g_low
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pat[gi] <= '0;
                end else if (i_cfg_we && i_cfg_index == CFG_PAT_LOW) begin
                    r_pat[gi] <= i_cfg_data[gi*BYTE_W +: BYTE_W];
                end
            end
        end else begin : g_high
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pat[gi] <= '0;
                end else if (i_cfg_we && i_cfg_index == CFG_PAT_HIGH) begin
                    r_pat[gi] <= i_cfg_data[(gi-BYTES_PER_WORD)*BYTE_W +: BYTE_W];
                end
            end
        end
    end

    // pattern length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CFG_LEN_W'(1);
        end else if (i_cfg_we && i_cfg_index == CFG_PAT_LEN) begin
            r_len <= i_cfg_data[CFG_LEN_W-1:0];
        end
    end

    // clamp length into one to max pattern
    always_comb begin
        if (r_len == '0) begin
            len_clamped = CFG_LEN_W'(1);
        end else if (r_len > CFG_LEN_W'(MAX_PATTERN)) begin
            len_clamped = CFG_LEN_W'(MAX_PATTERN);
        end else begin
            len_clamped = r_len;
        end
    end

    assign o_eff_len = LEN_W'(len_clamped);

    // shared byte select and compare
    always_comb begin
        if ({1'b0, i_sel_idx} < (IDX_W+1)'(MAX_PATTERN)) begin
            sel_byte = r_pat[i_sel_idx];
        end else begin
            sel_byte = '0;
        end
    end

    assign o_view.sel_byte = sel_byte;
    assign o_view.byte_eq  = (sel_byte == i_cmp_byte);

endmodule

FILE: rtl/stream_substring_deleter.sv
// ----------------------------------------------------------------------------
// stream_substring_deleter
// removes every occurrence of a configured byte pattern from a text stream
// ----------------------------------------------------------------------------
// a byte that extends a match, or a mismatch with nothing held, keeps the block idle
// a mismatch with k > 0 held bytes runs in steps: the accept, a replay of the k bytes
//   through the shared pattern select unit, then the byte itself
// an end of text with k held bytes: accept, then replay; a stall holds each step
// reset clears the match count, the sequencer, the output valid and the
//   pattern registers (length back to one)
module stream_substring_deleter
    import ssd_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ssd_stream_if.sink            i_in,
    ssd_stream_if.source          o_out
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_TAIL  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_flush_n, n_flush_n;
    logic              r_tail, n_tail;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_pat_view         view;
    logic [LEN_W-1:0]  eff_len;
    logic [IDX_W-1:0]  sel_idx;
    logic              slot_free;
    logic              acc;
    logic              hit;
    logic [LEN_W-1:0]  c1;
    logic [LEN_W-1:0]  c1_wrap;
    logic              flush_fin;

    // shared pattern select and compare unit
    ssd_pattern #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W),
        .LEN_W       (LEN_W)
    ) u_pattern (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sel_idx   (sel_idx),
        .i_cmp_byte  (i_in.payload.text_byte),
        .o_view      (view),
        .o_eff_len   (eff_len)
    );

    assign sel_idx   = (r_state == ST_IDLE) ? r_count : r_idx;
    assign slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && slot_free;
    assign acc       = i_in.valid && i_in.ready;

    // match test against the next pattern byte
    assign hit       = (LEN_W'(r_count) < eff_len) && view.byte_eq;
    assign c1        = LEN_W'(r_count) + LEN_W'(1);
    assign c1_wrap   = (c1 >= eff_len) ? '0 : c1;
    assign flush_fin = (r_idx == IDX_W'(r_flush_n - IDX_W'(1)));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_flush_n   = r_flush_n;
        n_tail      = r_tail;
        n_byte      = r_byte;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_byte = i_in.payload.text_byte;
                    n_last = i_in.payload.end_of_text;
                    n_idx  = '0;
                    if (hit && !i_in.payload.end_of_text) begin
                        n_count = IDX_W'(c1_wrap);
                    end else if (hit) begin
                        n_count = '0;
                        if (c1_wrap == '0) begin
                            // empty end marker
                            n_out.out_byte     = '0;
                            n_out.byte_present = 1'b0;
                            n_out.run_last     = 1'b1;
                            n_out.text_done    = 1'b1;
                            n_out_valid        = 1'b1;
                        end else begin
                            n_flush_n = IDX_W'(c1_wrap);
                            n_tail    = 1'b0;
                            n_state   = ST_FLUSH;
                        end
                    end else begin
                        n_count = '0;
                        if (r_count == '0) begin
                            n_out.out_byte     = i_in.payload.text_byte;
                            n_out.byte_present = 1'b1;
                            n_out.run_last     = 1'b1;
                            n_out.text_done    = i_in.payload.end_of_text;
                            n_out_valid        = 1'b1;
                        end else begin
                            n_flush_n = r_count;
                            n_tail    = 1'b1;
                            n_state   = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                // replay one held pattern byte per cycle while the output slot is free
                if (slot_free) begin
                    n_out.out_byte     = view.sel_byte;
                    n_out.byte_present = 1'b1;
                    n_out.run_last     = flush_fin && !r_tail;
                    n_out.text_done    = flush_fin && !r_tail && r_last;
                    n_out_valid        = 1'b1;
                    if (flush_fin) begin
                        n_state = r_tail ? ST_TAIL : ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_TAIL: begin
                // the mismatching byte itself
                if (slot_free) begin
                    n_out.out_byte     = r_byte;
                    n_out.byte_present = 1'b1;
                    n_out.run_last     = 1'b1;
                    n_out.text_done    = r_last;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_flush_n <= n_flush_n;
        r_tail    <= n_tail;
        r_byte    <= n_byte;
        r_last    <= n_last;
        r_out     <= n_out;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // the end of a text leaves no held prefix behind
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.payload.end_of_text |=> r_count == '0)
        else $error("match count not cleared after end of text");

    // replay index stays inside the held prefix
    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> r_idx < r_flush_n)
        else $error("flush index beyond held prefix");

    // the final result of a text always closes its input's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.text_done |-> r_out.run_last)
        else $error("text done without run last");

    // a held count never reaches the pattern capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_count) < LEN_W'(MAX_PATTERN))
        else $error("match count out of range");

endmodule

FILE: bench/stream_substring_deleter_tb.sv
// ----------------------------------------------------------------------------
// stream_substring_deleter_tb
// checks pattern removal on a byte stream against a cycle-free prediction:
// directed texts cover the pattern and length extremes, a length lowered
// while a match is held, and end-of-text flushes; random texts built from
// pattern fragments and noise run under several patterns, with bursty input,
// a stalling output and one long output hold-off
// ----------------------------------------------------------------------------
module stream_substring_deleter_tb;
    import ssd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN     = DEF_MAX_PATTERN;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 40;
    localparam int PHASE_ITEMS     = 50;
    localparam int RANDOM_PHASES   = 6;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_e;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssd_stream_if #(.T_PAYLOAD(t_in_item))  in_if ();
    ssd_stream_if #(.T_PAYLOAD(t_out_item)) out_if ();

    stream_substring_deleter #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // mirror of the pattern registers and the held match count
    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [CFG_LEN_W-1:0]  pat_len;
    int                    held_count;

    t_out_item expected_bytes[$];
    int        err_count;
    int        items_sent;
    int        burst_left;
    bit        sender_gaps;
    bit        hold_off_req;
    int        idle_cycles;

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    function automatic logic [BYTE_W-1:0] pattern_byte(input int idx);
        if (idx < BYTES_PER_WORD) begin
            return pat_low[BYTE_W*idx +: BYTE_W];
        end
        if (idx < 2*BYTES_PER_WORD) begin
            return pat_high[BYTE_W*(idx-BYTES_PER_WORD) +: BYTE_W];
        end
        return '0;
    endfunction

    function automatic int effective_length();
        int n;
        n = int'(pat_len);
        if (n < 1) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    // expected output of one accepted text byte
    task automatic predict_filtered_bytes(input t_in_item item);
        t_out_item step_out[$];
        t_out_item r;
        int        len;
        bit        matched;
        bit        release_held;
        len = effective_length();
        matched = (held_count < len) && (item.text_byte == pattern_byte(held_count));
        if (matched) begin
            held_count++;
            if (held_count >= len) held_count = 0;
            release_held = item.end_of_text;
        end else begin
            release_held = 1'b1;
        end
        if (release_held) begin
            for (int i = 0; i < held_count && i < MAX_PATTERN - 1; i++) begin
                r = '{out_byte: pattern_byte(i), byte_present: 1'b1,
                      run_last: 1'b0, text_done: 1'b0};
                step_out.push_back(r);
            end
        end
        if (!matched) begin
            r = '{out_byte: item.text_byte, byte_present: 1'b1,
                  run_last: 1'b0, text_done: 1'b0};
            step_out.push_back(r);
            held_count = 0;
        end
        if (item.end_of_text) begin
            // empty end marker when nothing else closes the text
            if (step_out.size() == 0) begin
                r = '{out_byte: '0, byte_present: 1'b0, run_last: 1'b0, text_done: 1'b0};
                step_out.push_back(r);
            end
            step_out[step_out.size()-1].text_done = 1'b1;
            held_count = 0;
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size()-1].run_last = 1'b1;
        end
        foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
    endtask

    // register write, mirrored at once since the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PAT_LOW:  pat_low  = data;
            CFG_PAT_HIGH: pat_high = data;
            CFG_PAT_LEN:  pat_len  = data[CFG_LEN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one input transfer, with bursts and gaps when enabled
    task automatic send_item(input logic [BYTE_W-1:0] b, input bit eot);
        t_in_item item;
        int       gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        item.text_byte   = b;
        item.end_of_text = eot;
        in_if.valid   <= 1'b1;
        in_if.payload <= item;
        do @(posedge i_clk); while (!in_if.ready);
        predict_filtered_bytes(item);
        items_sent++;
    endtask

    // stop offering and let every pending result come out
    task automatic wait_for_idle();
        in_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_random_pattern();
        logic [CFG_DATA_W-1:0] words[2];
        logic [CFG_LEN_W-1:0]  len_code;
        logic [BYTE_W-1:0]     pb;
        bit                    narrow;
        narrow = $urandom_range(0, 1);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            // a two-letter alphabet gives many overlapping near-matches
            pb = narrow ? BYTE_W'(8'h61 + $urandom_range(0, 1)) : BYTE_W'($urandom_range(0, 255));
            words[k/BYTES_PER_WORD][BYTE_W*(k%BYTES_PER_WORD) +: BYTE_W] = pb;
        end
        case ($urandom_range(0, 7))
            0:       len_code = '0;
            1:       len_code = CFG_LEN_W'($urandom_range(17, 31));
            2, 3:    len_code = CFG_LEN_W'($urandom_range(7, 16));
            default: len_code = CFG_LEN_W'($urandom_range(1, 6));
        endcase
        write_reg(CFG_PAT_LOW, words[0]);
        write_reg(CFG_PAT_HIGH, words[1]);
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(len_code));
    endtask

    // text built from whole patterns, broken prefixes and noise
    task automatic send_random_text(input bit close_text);
        logic [BYTE_W-1:0] text_q[$];
        int                len;
        int                k;
        len = effective_length();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    for (int j = 0; j < len; j++) text_q.push_back(pattern_byte(j));
                end
                2: begin
                    k = $urandom_range(0, len - 1);
                    for (int j = 0; j < k; j++) text_q.push_back(pattern_byte(j));
                    text_q.push_back(BYTE_W'($urandom_range(0, 255)));
                end
                3: text_q.push_back(pattern_byte($urandom_range(0, len - 1)));
                4: text_q.push_back(BYTE_W'($urandom_range(0, 255)));
                default: begin
                    text_q.push_back(pattern_byte(0));
                    text_q.push_back(pattern_byte(0));
                end
            endcase
        end
        foreach (text_q[i]) begin
            send_item(text_q[i], close_text && (i == text_q.size() - 1));
        end
    endtask

    // reset pattern: one zero byte
    task automatic test_reset_pattern();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // longest held prefix released by a mismatch, length above range
    task automatic test_longest_prefix_flush();
        wait_for_idle();
        write_reg(CFG_PAT_LOW, '1);
        write_reg(CFG_PAT_HIGH, '1);
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(31));
        repeat (MAX_PATTERN - 1) send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // match held while the length drops to the held count
    task automatic test_length_lowered_mid_match();
        wait_for_idle();
        write_reg(CFG_PAT_HIGH, '0);
        write_reg(CFG_PAT_LOW, CFG_DATA_W'(64'h0000_0000_0063_6261));
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(3));
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        wait_for_idle();
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(2));
        send_item(8'h63, 1'b1);
    endtask

    // zero length acts as one
    task automatic test_length_zero();
        wait_for_idle();
        write_reg(CFG_PAT_LEN, '0);
        send_item(8'h61, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(8'h61, 1'b1);
    endtask

    // partial match flushed at end of text
    task automatic test_flush_at_end();
        wait_for_idle();
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(3));
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);
    endtask

    // random texts over several patterns, some left open across a change
    task automatic test_random_texts();
        int phase_start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_idle();
            load_random_pattern();
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_random_text(1'b1);
            if ($urandom_range(0, 3) == 0) send_random_text(1'b0);
        end
    endtask

    // output held off while input keeps coming, so the block backs up
    task automatic test_receiver_hold_off();
        int start_count;
        wait_for_idle();
        load_random_pattern();
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        start_count  = items_sent;
        while (items_sent - start_count < 40) send_random_text(1'b1);
        sender_gaps = 1'b1;
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h", got.out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              got.out_byte, want.out_byte));
                if (got.byte_present !== want.byte_present)
                    report_mismatch($sformatf("byte_present %b, want %b",
                                              got.byte_present, want.byte_present));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              got.run_last, want.run_last));
                if (got.text_done !== want.text_done)
                    report_mismatch($sformatf("text_done %b, want %b",
                                              got.text_done, want.text_done));
            end
        end
    end

    // receiver stall pattern and long hold-off
    initial begin
        rx_mode_e mode;
        int       seg_left;
        int       period;
        int       phase;
        int       hold_left;
        out_if.ready <= 1'b0;
        mode      = RX_ALWAYS;
        seg_left  = 0;
        period    = 2;
        phase     = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (seg_left == 0) begin
                mode     = rx_mode_e'($urandom_range(0, 2));
                seg_left = $urandom_range(16, 160);
                period   = $urandom_range(2, 7);
            end
            seg_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS:   out_if.ready <= 1'b1;
                    RX_RANDOM:   out_if.ready <= ($urandom_range(0, 2) != 0);
                    default:     out_if.ready <= ((phase % period) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        pat_low      = '0;
        pat_high     = '0;
        pat_len      = CFG_LEN_W'(1);
        held_count   = 0;
        err_count    = 0;
        items_sent   = 0;
        burst_left   = 0;
        sender_gaps  = 1'b1;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pattern();
        test_longest_prefix_flush();
        test_length_lowered_mid_match();
        test_length_zero();
        test_flush_at_end();
        test_random_texts();
        test_receiver_hold_off();

        wait_for_idle();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
